/* design/gid_pkg.sv */
// ----------------------------------------------------------------------------
// gid_pkg: shared types and constants for the group number assigner
// Word layouts of both channels, field widths, hash constant and defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package gid_pkg;

  // field widths of the channel words
  localparam int GID_KEY_FIELD_W = 64;
  localparam int GID_ID_W        = 10;
  localparam int GID_COUNT_W     = 11;

  // defaults for the top level parameters
  localparam int GID_CAPACITY    = 1024;
  localparam int GID_KEY_WIDTH   = 64;

  // width of the table generation mark kept with every slot
  localparam int GID_EPOCH_W     = 4;

  // multiplicative hash constant
  localparam logic [63:0] GID_HASH_MULT = 64'h9E37_79B9_7F4A_7C15;

  typedef struct packed {
    logic [GID_KEY_FIELD_W-1:0] key;
    logic                       first_row;
  } gid_in_t;

  typedef struct packed {
    logic [GID_ID_W-1:0]    grp_num;
    logic                   new_group;
    logic                   overflow;
    logic [GID_COUNT_W-1:0] group_count;
  } gid_out_t;

endpackage

`default_nettype wire

/* design/gid_ram.sv */
// ----------------------------------------------------------------------------
// gid_ram: generic single write, single read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module gid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* design/gid_hash.sv */
// ----------------------------------------------------------------------------
// gid_hash: home slot of a key
// One shared 32x32 multiplier builds bits 63:32 of key * constant in three
// partial products; the same multiplier then forms a reciprocal quotient
// estimate, and one compare-subtract finishes the reduction modulo CAPACITY
// (skipped when CAPACITY is a power of two).
// ----------------------------------------------------------------------------
`default_nettype none

module gid_hash
  import gid_pkg::*;
#(
  parameter int CAPACITY = GID_CAPACITY
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [GID_KEY_FIELD_W-1:0]  key,
  output      logic                        done,
  output      logic [$clog2(CAPACITY)-1:0] slot
);

  localparam int  SLOT_W  = $clog2(CAPACITY);
  localparam bit  IS_POW2 = (CAPACITY & (CAPACITY - 1)) == 0;
  localparam logic [SLOT_W:0] CAP_V = (SLOT_W+1)'(CAPACITY);
  localparam logic [31:0]     RECIP = 32'((64'd1 << 32) / CAPACITY);
  localparam logic [31:0]     CAP_M = 32'(CAPACITY);

  typedef enum logic [3:0] {
    H_IDLE = 4'b0001,
    H_MUL  = 4'b0010,
    H_MOD  = 4'b0100,
    H_DONE = 4'b1000
  } hstate_t;

  hstate_t                    state_r, state_nxt;
  logic [1:0]                 step_r, step_nxt;
  logic [31:0]                acc_r, acc_nxt;
  logic [63:0]                prod_r, prod_nxt;
  logic [63:0]                key_r, key_nxt;
  logic [SLOT_W-1:0]          slot_r, slot_nxt;

  logic [31:0]                mul_a, mul_b;
  logic [SLOT_W:0]            rem_raw;
  logic [SLOT_W-1:0]          rem_fix;

  // operand select for the shared multiplier
  always_comb begin
    if (state_r == H_MOD) begin
      mul_a = (step_r == 2'd0) ? acc_r : prod_r[63:32];
      mul_b = (step_r == 2'd0) ? RECIP : CAP_M;
    end else begin
      mul_a = (step_r == 2'd1) ? key_r[63:32] : key_r[31:0];
      mul_b = (step_r == 2'd2) ? GID_HASH_MULT[63:32] : GID_HASH_MULT[31:0];
    end
  end

  // quotient estimate is low by at most one: one final subtract
  assign rem_raw = acc_r[SLOT_W:0];
  assign rem_fix = (rem_raw >= CAP_V) ? SLOT_W'(rem_raw - CAP_V) : rem_raw[SLOT_W-1:0];

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    acc_nxt   = acc_r;
    prod_nxt  = prod_r;
    key_nxt   = key_r;
    slot_nxt  = slot_r;
    unique case (state_r)
      H_IDLE: begin
        if (start) begin
          key_nxt   = key;
          step_nxt  = 2'd0;
          acc_nxt   = '0;
          state_nxt = H_MUL;
        end
      end
      H_MUL: begin
        // product of step n is folded into acc in step n+1
        prod_nxt = mul_a * mul_b;
        step_nxt = step_r + 2'd1;
        case (step_r)
          2'd1:    acc_nxt = prod_r[63:32];
          2'd2:    acc_nxt = acc_r + prod_r[31:0];
          2'd3:    acc_nxt = acc_r + prod_r[31:0];
          default: acc_nxt = acc_r;
        endcase
        if (step_r == 2'd3) begin
          step_nxt  = 2'd0;
          state_nxt = H_MOD;
        end
      end
      H_MOD: begin
        if (IS_POW2) begin
          slot_nxt  = acc_r[SLOT_W-1:0];
          state_nxt = H_DONE;
        end else begin
          // h * recip, then quotient * CAPACITY, then h minus that
          prod_nxt = mul_a * mul_b;
          step_nxt = step_r + 2'd1;
          case (step_r)
            2'd2:    acc_nxt = acc_r - prod_r[31:0];
            2'd3: begin
              slot_nxt  = rem_fix;
              state_nxt = H_DONE;
            end
            default: acc_nxt = acc_r;
          endcase
        end
      end
      H_DONE: begin
        state_nxt = H_IDLE;
      end
      default: begin
        state_nxt = H_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= H_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    step_r <= step_nxt;
    acc_r  <= acc_nxt;
    prod_r <= prod_nxt;
    key_r  <= key_nxt;
    slot_r <= slot_nxt;
  end

  assign done = (state_r == H_DONE);
  assign slot = slot_r;

endmodule

`default_nettype wire

/* design/group_id_assigner.sv */
// Flow: a taken word goes through the hash unit to its home slot (plus the modulo steps
//   when CAPACITY is not a power of two), then a read and a compare per slot probed,
//   then the output register. Throughput: one word at a time; the next word is taken
//   the cycle after the result has moved into the output register.
// Reset: a clearing sweep marks every slot empty; a first-row word that wraps the
//   table generation mark repeats that sweep.
// ----------------------------------------------------------------------------
// group_id_assigner: dense group numbers for a hash group-by
// Linear-probing hash table in one RAM; each slot holds key, group number and
// the generation mark that tells whether it belongs to the current table.
// ----------------------------------------------------------------------------
`default_nettype none

module group_id_assigner
  import gid_pkg::*;
#(
  parameter int CAPACITY  = GID_CAPACITY,
  parameter int KEY_WIDTH = GID_KEY_WIDTH
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output      logic     in_ready,
  input  wire gid_in_t  in_data,
  output      logic     out_valid,
  input  wire logic     out_ready,
  output      gid_out_t out_data
);

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int WORD_W = GID_EPOCH_W + SLOT_W + KEY_WIDTH;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0]  CAP_CNT   = CNT_W'(CAPACITY);

  typedef enum logic [5:0] {
    S_SWEEP = 6'b000001,
    S_IDLE  = 6'b000010,
    S_HASH  = 6'b000100,
    S_READ  = 6'b001000,
    S_CMP   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [SLOT_W-1:0]      sweep_r, sweep_nxt;
  logic                   pend_r, pend_nxt;
  logic [KEY_WIDTH-1:0]   key_r, key_nxt;
  logic [GID_EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic [CNT_W-1:0]       next_id_r, next_id_nxt;
  logic [SLOT_W-1:0]      slot_r, slot_nxt;
  logic [SLOT_W-1:0]      probe_r, probe_nxt;
  logic                   hstart_r, hstart_nxt;
  gid_out_t               res_r, res_nxt;
  logic                   out_valid_r, out_valid_nxt;
  gid_out_t               out_data_r, out_data_nxt;

  logic                   in_acc;
  logic                   hash_done;
  logic [SLOT_W-1:0]      hash_slot;
  logic                   wr_en;
  logic [SLOT_W-1:0]      wr_addr;
  logic [WORD_W-1:0]      wr_data;
  logic [WORD_W-1:0]      rd_word;
  logic [KEY_WIDTH-1:0]   rd_key;
  logic [SLOT_W-1:0]      rd_id;
  logic [GID_EPOCH_W-1:0] rd_epoch;
  logic [CNT_W-1:0]       id_inc;

  // home slot unit
  gid_hash #(
    .CAPACITY (CAPACITY)
  ) u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hstart_r),
    .key   (GID_KEY_FIELD_W'(key_r)),
    .done  (hash_done),
    .slot  (hash_slot)
  );

  // slot store: {epoch, group number, key}
  gid_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (slot_r),
    .rd_data (rd_word)
  );

  assign rd_key   = rd_word[KEY_WIDTH-1:0];
  assign rd_id    = rd_word[KEY_WIDTH +: SLOT_W];
  assign rd_epoch = rd_word[KEY_WIDTH + SLOT_W +: GID_EPOCH_W];
  assign id_inc   = next_id_r + CNT_W'(1);

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  // probe sequencer
  always_comb begin
    state_nxt     = state_r;
    sweep_nxt     = sweep_r;
    pend_nxt      = pend_r;
    key_nxt       = key_r;
    epoch_nxt     = epoch_r;
    next_id_nxt   = next_id_r;
    slot_nxt      = slot_r;
    probe_nxt     = probe_r;
    hstart_nxt    = 1'b0;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    wr_en         = 1'b0;
    wr_addr       = slot_r;
    wr_data       = {epoch_r, SLOT_W'(next_id_r), key_r};
    unique case (state_r)
      S_SWEEP: begin
        // mark every slot as belonging to generation zero
        wr_en     = 1'b1;
        wr_addr   = sweep_r;
        wr_data   = '0;
        sweep_nxt = sweep_r + SLOT_W'(1);
        if (sweep_r == LAST_SLOT) begin
          sweep_nxt  = '0;
          epoch_nxt  = GID_EPOCH_W'(1);
          pend_nxt   = 1'b0;
          hstart_nxt = pend_r;
          state_nxt  = pend_r ? S_HASH : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          key_nxt = in_data.key[KEY_WIDTH-1:0];
          if (in_data.first_row) begin
            next_id_nxt = '0;
            if (epoch_r == '1) begin
              pend_nxt  = 1'b1;
              state_nxt = S_SWEEP;
            end else begin
              epoch_nxt  = epoch_r + GID_EPOCH_W'(1);
              hstart_nxt = 1'b1;
              state_nxt  = S_HASH;
            end
          end else begin
            hstart_nxt = 1'b1;
            state_nxt  = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (hash_done) begin
          slot_nxt  = hash_slot;
          probe_nxt = '0;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (rd_epoch != epoch_r) begin
          // empty slot: claim it if numbers remain
          if (next_id_r < CAP_CNT) begin
            wr_en                 = 1'b1;
            next_id_nxt           = id_inc;
            res_nxt.grp_num       = GID_ID_W'(next_id_r);
            res_nxt.new_group     = 1'b1;
            res_nxt.overflow      = 1'b0;
            res_nxt.group_count   = GID_COUNT_W'(id_inc);
          end else begin
            res_nxt.grp_num       = '0;
            res_nxt.new_group     = 1'b0;
            res_nxt.overflow      = 1'b1;
            res_nxt.group_count   = GID_COUNT_W'(next_id_r);
          end
          state_nxt = S_DONE;
        end else if (rd_key == key_r) begin
          res_nxt.grp_num     = GID_ID_W'(rd_id);
          res_nxt.new_group   = 1'b0;
          res_nxt.overflow    = 1'b0;
          res_nxt.group_count = GID_COUNT_W'(next_id_r);
          state_nxt           = S_DONE;
        end else if (probe_r == LAST_SLOT) begin
          // walked every slot without a match or a hole
          res_nxt.grp_num     = '0;
          res_nxt.new_group   = 1'b0;
          res_nxt.overflow    = 1'b1;
          res_nxt.group_count = GID_COUNT_W'(next_id_r);
          state_nxt           = S_DONE;
        end else begin
          slot_nxt  = (slot_r == LAST_SLOT) ? '0 : slot_r + SLOT_W'(1);
          probe_nxt = probe_r + SLOT_W'(1);
          state_nxt = S_READ;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      sweep_r     <= '0;
      pend_r      <= 1'b0;
      epoch_r     <= GID_EPOCH_W'(1);
      next_id_r   <= '0;
      hstart_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      pend_r      <= pend_nxt;
      epoch_r     <= epoch_nxt;
      next_id_r   <= next_id_nxt;
      hstart_r    <= hstart_nxt;
      out_valid_r <= out_valid_nxt;
    end
    key_r      <= key_nxt;
    slot_r     <= slot_nxt;
    probe_r    <= probe_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* design/gid_checker.sv */
// ----------------------------------------------------------------------------
// gid_checker: port-level checks for the group number assigner
// Watches both channels of the top level; attached by bind below.
// ----------------------------------------------------------------------------
`default_nettype none

module gid_checker
  import gid_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_ready,
  input wire gid_in_t  in_data,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire gid_out_t out_data
);

  // no result word right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // one word in flight: input closes after it takes a word
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input still open after taking a word");

  // overflow carries group number zero and never a new group
  a_overflow_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.overflow) |-> (!out_data.new_group && out_data.grp_num == '0))
    else $error("overflow word with group fields set");

  // a waiting result holds its word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result word dropped or changed while stalled");

endmodule

bind group_id_assigner gid_checker u_gid_checker (.*);

`default_nettype wire
